// ===== sv/wfs_pkg.sv =====
// Shared constants, types and helper functions for the wall-follow steering block.
package wfs_pkg;

  localparam int SAMPLES_DEF = 10;

  localparam int DIV_W = 24;
  localparam int DEN_W = 16;

  localparam logic [23:0] DIST_NUM = 24'd6572654;
  localparam logic [23:0] DIST_OFS = 24'd626;
  localparam int          POT_STEP = 40;
  localparam logic [15:0] FAST_DIV = 16'd100;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_STOP   = 2'd1;
  localparam logic [1:0] CMD_GO     = 2'd2;

  localparam logic [2:0] REG_PWM_PERIOD    = 3'd0;
  localparam logic [2:0] REG_CLOSE_LIMIT   = 3'd1;
  localparam logic [2:0] REG_FAR_LIMIT     = 3'd2;
  localparam logic [2:0] REG_SIDE_LIMIT    = 3'd3;
  localparam logic [2:0] REG_BALANCE_BAND  = 3'd4;
  localparam logic [2:0] REG_SLOW_DIVISOR  = 3'd5;
  localparam logic [2:0] REG_CRAWL_DIVISOR = 3'd6;
  localparam logic [2:0] REG_CRAWL_OFFSET  = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOAD   = 4'b0010,
    ST_WAIT   = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_t;

  typedef enum logic [8:0] {
    OP_AVGL  = 9'b000000001,
    OP_QL    = 9'b000000010,
    OP_AVGR  = 9'b000000100,
    OP_QR    = 9'b000001000,
    OP_POW   = 9'b000010000,
    OP_FAST  = 9'b000100000,
    OP_SLOW  = 9'b001000000,
    OP_CRAWL = 9'b010000000,
    OP_GO    = 9'b100000000
  } op_t;

  function automatic logic [15:0] sat16(input logic [23:0] v);
    sat16 = (v[23:16] != 8'd0) ? 16'hFFFF : v[15:0];
  endfunction

  // Quotient of the distance constant by the average, less the offset, clamped.
  function automatic logic [15:0] dist_q88(input logic [23:0] q);
    dist_q88 = (q < DIST_OFS) ? 16'd0 : sat16(q - DIST_OFS);
  endfunction

endpackage

// ===== sv/wfs_in_if.sv =====
// Input channel: command word with one sensor triple.
interface wfs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [11:0] left_sample;
  logic [11:0] right_sample;
  logic [11:0] pot_sample;

  modport source (output valid, command, left_sample, right_sample, pot_sample,
                  input ready);
  modport sink (input valid, command, left_sample, right_sample, pot_sample,
                output ready);
endinterface

// ===== sv/wfs_out_if.sv =====
// Result channel: wheel duties, distances and power percent.
interface wfs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] left_duty;
  logic [15:0] right_duty;
  logic [15:0] left_distance;
  logic [15:0] right_distance;
  logic [6:0]  power_percent;

  modport source (output valid, left_duty, right_duty, left_distance, right_distance,
                  power_percent, input ready);
  modport sink (input valid, left_duty, right_duty, left_distance, right_distance,
                power_percent, output ready);
endinterface

// ===== sv/wall_follow_steering_top.sv =====
// Top level of the wall-follow steering block: sequencer, state and config registers.
//
//  channel   direction  handshake       word
//  in_ch     in         valid/ready     command, left/right/pot samples
//  out_ch    out        valid/ready     duties, distances, power percent
//  cfg_*     in         write enable    register index, write data
//
// A stop word or a sample word that does not end a group is handled in the idle state; a go word runs one division.
// The final sample of a group runs eight divisions through one shared divider
// before the result is loaded.
// Reset loads the register defaults and clears the sums and the output valid flag.
// The result waits in the output register; input is taken again once it is loaded.
module wall_follow_steering_top #(
  parameter int SAMPLES = wfs_pkg::SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  wfs_in_if.sink      in_ch,
  wfs_out_if.source   out_ch,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import wfs_pkg::*;

  localparam logic [15:0] SAMP_DIV = 16'(SAMPLES);
  localparam logic [15:0] POT_DIV  = 16'(SAMPLES * POT_STEP);

  logic [15:0] pwm_r, offset_r;
  logic [7:0]  close_r, far_r, side_r, band_r;
  logic [9:0]  slow_div_r, crawl_div_r;

  logic [15:0] left_sum_r, right_sum_r, pot_sum_r;
  logic [3:0]  count_r;
  logic [6:0]  power_r;
  logic [15:0] base_r;

  state_t      state_r;
  op_t         op_r;
  logic [15:0] avg_r, dl_r, dr_r, fast_r, slow_r, crawl_r;

  logic        out_valid_r;
  logic [15:0] out_ld_r, out_rd_r, out_dl_r, out_dr_r;
  logic [6:0]  out_pow_r;

  logic                div_start, div_done;
  logic [DIV_W-1:0]    div_num, div_q;
  logic [DEN_W-1:0]    div_den;
  logic [22:0]         prod;
  logic [15:0]         crawl_off, ld, rd;
  logic                in_acc, out_free;
  logic [3:0]          count_inc;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign count_inc   = count_r + 4'd1;
  assign div_start   = (state_r == ST_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_r       <= 16'd25000;
      close_r     <= 8'd15;
      far_r       <= 8'd70;
      side_r      <= 8'd20;
      band_r      <= 8'd20;
      slow_div_r  <= 10'd130;
      crawl_div_r <= 10'd180;
      offset_r    <= 16'd1000;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PWM_PERIOD:    pwm_r       <= cfg_data;
        REG_CLOSE_LIMIT:   close_r     <= cfg_data[7:0];
        REG_FAR_LIMIT:     far_r       <= cfg_data[7:0];
        REG_SIDE_LIMIT:    side_r      <= cfg_data[7:0];
        REG_BALANCE_BAND:  band_r      <= cfg_data[7:0];
        REG_SLOW_DIVISOR:  slow_div_r  <= cfg_data[9:0];
        REG_CRAWL_DIVISOR: crawl_div_r <= cfg_data[9:0];
        REG_CRAWL_OFFSET:  offset_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // One multiplier feeds the divider for the go base and the scaled duties.
  assign prod = (op_r == OP_GO) ? (23'(pwm_r) * 23'(power_r)) : (23'(base_r) * 23'(power_r));

  always_comb begin
    div_num = {1'b0, prod};
    div_den = FAST_DIV;
    case (op_r)
      OP_AVGL:  begin div_num = {8'd0, left_sum_r};  div_den = SAMP_DIV; end
      OP_AVGR:  begin div_num = {8'd0, right_sum_r}; div_den = SAMP_DIV; end
      OP_QL:    begin div_num = DIST_NUM; div_den = avg_r; end
      OP_QR:    begin div_num = DIST_NUM; div_den = avg_r; end
      OP_POW:   begin div_num = {8'd0, pot_sum_r};   div_den = POT_DIV; end
      OP_FAST:  div_den = FAST_DIV;
      OP_SLOW:  div_den = (slow_div_r == 10'd0) ? 16'd1 : {6'd0, slow_div_r};
      OP_CRAWL: div_den = (crawl_div_r == 10'd0) ? 16'd1 : {6'd0, crawl_div_r};
      OP_GO:    div_den = FAST_DIV;
      default:  div_den = FAST_DIV;
    endcase
  end

  wfs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  assign crawl_off = (crawl_r > offset_r) ? (crawl_r - offset_r) : 16'd0;

  always_comb begin
    if (dl_r < {close_r, 8'h00} && dr_r < {close_r, 8'h00}) begin
      if (dl_r < dr_r) begin
        ld = crawl_r; rd = 16'd1;
      end else begin
        ld = 16'd1; rd = crawl_r;
      end
    end else if (dl_r > {far_r, 8'h00} && dr_r > {far_r, 8'h00}) begin
      ld = 16'd1; rd = 16'd1;
    end else if (dl_r < {side_r, 8'h00}) begin
      ld = fast_r; rd = crawl_off;
    end else if (dr_r < {side_r, 8'h00}) begin
      ld = crawl_off; rd = fast_r;
    end else if (dl_r > dr_r) begin
      ld = ((dl_r - dr_r) < {band_r, 8'h00}) ? fast_r : slow_r;
      rd = fast_r;
    end else if (dr_r > dl_r) begin
      ld = fast_r;
      rd = ((dr_r - dl_r) < {band_r, 8'h00}) ? fast_r : slow_r;
    end else begin
      ld = fast_r; rd = fast_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_AVGL;
      left_sum_r  <= '0;
      right_sum_r <= '0;
      pot_sum_r   <= '0;
      count_r     <= '0;
      power_r     <= '0;
      base_r      <= 16'd25000;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_DECIDE && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_ch.command)
              CMD_SAMPLE: begin
                left_sum_r  <= left_sum_r + {4'd0, in_ch.left_sample};
                right_sum_r <= right_sum_r + {4'd0, in_ch.right_sample};
                pot_sum_r   <= pot_sum_r + {4'd0, in_ch.pot_sample};
                count_r     <= count_inc;
                if (count_inc == 4'(SAMPLES)) begin
                  op_r    <= OP_AVGL;
                  state_r <= ST_LOAD;
                end
              end
              CMD_STOP: base_r <= 16'd0;
              CMD_GO: begin
                op_r    <= OP_GO;
                state_r <= ST_LOAD;
              end
              default: ;
            endcase
          end
        end
        ST_LOAD: state_r <= ST_WAIT;
        ST_WAIT: begin
          if (div_done) begin
            state_r <= ST_LOAD;
            case (op_r)
              OP_AVGL:  begin avg_r <= div_q[15:0]; op_r <= OP_QL; end
              OP_QL:    begin dl_r <= dist_q88(div_q); op_r <= OP_AVGR; end
              OP_AVGR:  begin avg_r <= div_q[15:0]; op_r <= OP_QR; end
              OP_QR:    begin dr_r <= dist_q88(div_q); op_r <= OP_POW; end
              OP_POW:   begin power_r <= div_q[6:0]; op_r <= OP_FAST; end
              OP_FAST:  begin fast_r <= sat16(div_q); op_r <= OP_SLOW; end
              OP_SLOW:  begin slow_r <= sat16(div_q); op_r <= OP_CRAWL; end
              OP_CRAWL: begin crawl_r <= sat16(div_q); state_r <= ST_DECIDE; end
              OP_GO:    begin base_r <= sat16(div_q); state_r <= ST_IDLE; end
              default:  state_r <= ST_IDLE;
            endcase
          end
        end
        ST_DECIDE: begin
          if (out_free) begin
            left_sum_r  <= '0;
            right_sum_r <= '0;
            pot_sum_r   <= '0;
            count_r     <= '0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DECIDE && out_free) begin
      out_ld_r  <= ld;
      out_rd_r  <= rd;
      out_dl_r  <= dl_r;
      out_dr_r  <= dr_r;
      out_pow_r <= power_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.left_duty      = out_ld_r;
  assign out_ch.right_duty     = out_rd_r;
  assign out_ch.left_distance  = out_dl_r;
  assign out_ch.right_distance = out_dr_r;
  assign out_ch.power_percent  = out_pow_r;

endmodule

// ===== sv/wfs_div.sv =====
// Restoring divider, one quotient bit per cycle.
module wfs_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [wfs_pkg::DIV_W-1:0] dividend,
  input  logic [wfs_pkg::DEN_W-1:0] divisor,
  output logic                      done,
  output logic [wfs_pkg::DIV_W-1:0] quotient
);
  import wfs_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  assign rem_sh  = {rem_r, quo_r[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_nxt = ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
